FILE: rtl/ibc_pkg.sv
// Shared types and constants for the IMU bias calibration block.
package ibc_pkg;

	localparam int AXIS_W   = 16;
	localparam int GYRO_W   = 9;
	localparam int CORR_W   = 13;
	localparam int CNT_W    = 8;
	localparam int STEP_W   = 6;
	localparam int GRAV_W   = 15;
	localparam int IN_W     = 96;
	localparam int OUT_W    = 80;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [CNT_W-1:0]  COARSE_END = 8'd50;
	localparam logic [CNT_W-1:0]  MID_END    = 8'd100;
	localparam logic [STEP_W-1:0] STEP_COARSE = 6'd50;
	localparam logic [STEP_W-1:0] STEP_MID    = 6'd10;
	localparam logic [STEP_W-1:0] STEP_FINE   = 6'd1;
	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16384;

	localparam logic [AXIS_W-1:0] WORD_MASK = 16'hfffe;
	localparam logic [AXIS_W-1:0] KEEP_MASK = 16'h0001;

	localparam int DONE_BIT = 75;

	typedef enum logic [1:0] {
		REG_BIAS_X  = 2'd0,
		REG_BIAS_Y  = 2'd1,
		REG_BIAS_Z  = 2'd2,
		REG_GRAVITY = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              upd;
		logic [STEP_W-1:0] step;
	} ibc_ctrl_t;

endpackage

FILE: rtl/imu_bias_calibration.sv
// Top level of the IMU bias calibration block.
//
// Samples enter on the s_axis channel, one six-axis sample per transfer, and
// each accepted sample yields exactly one result transfer on m_axis carrying
// the three gyro offsets, the three accel offset register words and the done
// flag. The corrections are updated and the result is registered in the same
// cycle the sample is accepted, so a result appears in the cycle after its input
// transfer. One sample per cycle is sustained while the receiver is ready; the
// only storage between the channels is the single result register. The input is
// ready whenever that register is empty or is being emptied in the same cycle, so a
// stalled receiver holds the result and backs the stall up to the sender.
// After SAMPLE_COUNT samples the corrections freeze and every later result
// repeats them with done set. Reset clears the sample count and corrections,
// sets the factory biases to zero and the gravity target to one g (16384).
// The user must make APB port writes of the biases and the gravity target only
// while the block is idle; the block does not enforce it. pready is always high.
module imu_bias_calibration #(
	parameter int SAMPLE_COUNT = 200
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  logic [ibc_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// gyro_offset_x, gyro_offset_y, gyro_offset_z, accel_word_x,
	// accel_word_y, accel_word_z, done_res, zero fill
	output logic [ibc_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ibc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ibc_pkg::DATA_W-1:0]   pwdata,
	output logic [ibc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import ibc_pkg::*;

	localparam logic [CNT_W-1:0] SAMPLE_LIMIT = CNT_W'(SAMPLE_COUNT);

	logic [AXIS_W-1:0] bias_q [3];
	logic [GRAV_W-1:0] gravity_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              in_xfer;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	ibc_ctrl_t         ctrl;
	logic signed [GYRO_W-1:0] gyro_off [3];
	logic        [AXIS_W-1:0] accel_wd [3];
	logic signed [AXIS_W-1:0] target [3];
	logic              done_d;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q[0] <= '0;
			bias_q[1] <= '0;
			bias_q[2] <= '0;
			gravity_q <= GRAVITY_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BIAS_X:  bias_q[0] <= pwdata[AXIS_W-1:0];
				REG_BIAS_Y:  bias_q[1] <= pwdata[AXIS_W-1:0];
				REG_BIAS_Z:  bias_q[2] <= pwdata[AXIS_W-1:0];
				REG_GRAVITY: gravity_q <= pwdata[GRAV_W-1:0];
				default:     gravity_q <= gravity_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BIAS_X:  prdata = {{(DATA_W-AXIS_W){1'b0}}, bias_q[0]};
			REG_BIAS_Y:  prdata = {{(DATA_W-AXIS_W){1'b0}}, bias_q[1]};
			REG_BIAS_Z:  prdata = {{(DATA_W-AXIS_W){1'b0}}, bias_q[2]};
			REG_GRAVITY: prdata = {{(DATA_W-GRAV_W){1'b0}}, gravity_q};
			default:     prdata = '0;
		endcase
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_comb begin
		ctrl.upd = in_xfer && (count_q < SAMPLE_LIMIT);
		if (count_q < COARSE_END) begin
			ctrl.step = STEP_COARSE;
		end else if (count_q < MID_END) begin
			ctrl.step = STEP_MID;
		end else begin
			ctrl.step = STEP_FINE;
		end
	end

	assign count_d = ctrl.upd ? count_q + 1'b1 : count_q;
	assign done_d  = count_d >= SAMPLE_LIMIT;

	assign target[0] = '0;
	assign target[1] = '0;
	assign target[2] = $signed({1'b0, gravity_q});

	for (genvar i = 0; i < 3; i++) begin : g_axis
		ibc_axis u_axis (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.accel       ($signed(s_axis_tdata[i*AXIS_W +: AXIS_W])),
			.target      (target[i]),
			.gyro        ($signed(s_axis_tdata[(i+3)*AXIS_W +: AXIS_W])),
			.bias        (bias_q[i]),
			.gyro_offset (gyro_off[i]),
			.accel_word  (accel_wd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_xfer) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= {4'b0, done_d, accel_wd[2], accel_wd[1], accel_wd[0],
				gyro_off[2], gyro_off[1], gyro_off[0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/ibc_axis.sv
// Per-axis correction state and update for one accel and one gyro axis.
module ibc_axis (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ibc_pkg::ibc_ctrl_t             ctrl,
	input  logic signed [ibc_pkg::AXIS_W-1:0] accel,
	input  logic signed [ibc_pkg::AXIS_W-1:0] target,
	input  logic signed [ibc_pkg::AXIS_W-1:0] gyro,
	input  logic        [ibc_pkg::AXIS_W-1:0] bias,
	output logic signed [ibc_pkg::GYRO_W-1:0] gyro_offset,
	output logic        [ibc_pkg::AXIS_W-1:0] accel_word
);
	import ibc_pkg::*;

	logic signed [CORR_W-1:0] accel_corr_q;
	logic signed [CORR_W-1:0] accel_corr_d;
	logic signed [GYRO_W-1:0] gyro_corr_q;
	logic signed [GYRO_W-1:0] gyro_corr_d;
	logic signed [CORR_W-1:0] step_s;
	logic        [AXIS_W-1:0] diff;

	assign step_s = $signed({{(CORR_W-STEP_W){1'b0}}, ctrl.step});

	always_comb begin
		accel_corr_d = accel_corr_q;
		gyro_corr_d  = gyro_corr_q;
		if (ctrl.upd) begin
			if (accel > target) begin
				accel_corr_d = accel_corr_q + step_s;
			end else if (accel < target) begin
				accel_corr_d = accel_corr_q - step_s;
			end
			if (gyro > 16'sd1) begin
				gyro_corr_d = gyro_corr_q - 9'sd1;
			end else if (gyro < -16'sd1) begin
				gyro_corr_d = gyro_corr_q + 9'sd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_corr_q <= '0;
			gyro_corr_q  <= '0;
		end else begin
			accel_corr_q <= accel_corr_d;
			gyro_corr_q  <= gyro_corr_d;
		end
	end

	assign diff        = bias - AXIS_W'(accel_corr_d);
	assign accel_word  = (diff & WORD_MASK) | (bias & KEEP_MASK);
	assign gyro_offset = gyro_corr_d;

endmodule

FILE: rtl/ibc_checker.sv
// Port-level assertions for the IMU bias calibration block and their binding.
module ibc_assertions (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [ibc_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                      pready
);
	import ibc_pkg::*;

	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[DONE_BIT]) begin
			done_seen_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted sample produced no result");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready && pready)
		else $error("input not ready while result register is empty");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && done_seen_q |-> m_axis_tdata[DONE_BIT])
		else $error("done flag dropped after calibration finished");

endmodule

bind imu_bias_calibration ibc_assertions u_ibc_assertions (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.pready        (pready)
);
